// ===== hdl/hrks_pkg.sv =====
// ----------------------------------------------------------------------------
// hrks_pkg
// Shared types and constants for the history ring key search block.
// ----------------------------------------------------------------------------
package hrks_pkg;

    localparam int KEY_W  = 32;
    localparam int REC_W  = 3 * KEY_W;
    localparam int SLOT_W = 8;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  item_code;
        logic [KEY_W-1:0]  head_check;
        logic [KEY_W-1:0]  sum_check;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_out_item;

    typedef struct packed {
        logic      load;
        t_out_item item;
    } t_seq_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_seq_state;

endpackage

// ===== hdl/hrks_ram.sv =====
// ----------------------------------------------------------------------------
// hrks_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hrks_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hrks_seq.sv =====
// ----------------------------------------------------------------------------
// hrks_seq
// Sequencer that owns the ring pointers and walks the key ram one entry per
// cycle through a single 96-bit compare unit.
// ----------------------------------------------------------------------------
module hrks_seq
    import hrks_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  t_in_item                               i_in_item,
    input  logic                                   i_out_free,
    input  logic [REC_W-1:0]                       i_rd_data,
    output logic                                   o_in_stall,
    output logic                                   o_we,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_waddr,
    output logic [REC_W-1:0]                       o_wdata,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_raddr,
    output t_seq_res                               o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    t_seq_state        r_state, n_state;
    logic [AW-1:0]     r_ws, n_ws;
    logic [AW-1:0]     r_fill, n_fill;
    logic [REC_W-1:0]  r_key, n_key;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_left, n_left;
    logic              r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]     r_cmp_pos, n_cmp_pos;
    logic              r_cmp_last, n_cmp_last;
    t_out_item         r_res, n_res;

    logic              hit;
    logic [AW-1:0]     start_pos;
    logic [REC_W-1:0]  in_key;

    assign in_key = {i_in_item.item_code, i_in_item.head_check, i_in_item.sum_check};
    assign hit    = r_cmp_vld && (i_rd_data == r_key);

    // oldest searchable slot: write slot minus fill count, modulo depth
    always_comb begin
        if (r_ws >= r_fill) begin
            start_pos = r_ws - r_fill;
        end else begin
            start_pos = AW'({1'b0, r_ws} + (AW + 1)'(DEPTH) - {1'b0, r_fill});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ws      <= '0;
            r_fill    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ws      <= n_ws;
            r_fill    <= n_fill;
            r_cmp_vld <= n_cmp_vld;
        end
        r_key      <= n_key;
        r_pos      <= n_pos;
        r_left     <= n_left;
        r_cmp_pos  <= n_cmp_pos;
        r_cmp_last <= n_cmp_last;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_ws       = r_ws;
        n_fill     = r_fill;
        n_key      = r_key;
        n_pos      = r_pos;
        n_left     = r_left;
        n_cmp_vld  = 1'b0;
        n_cmp_pos  = r_pos;
        n_cmp_last = (r_left == AW'(1));
        n_res      = r_res;
        o_in_stall = 1'b1;
        o_we       = 1'b0;
        o_waddr    = r_ws;
        o_wdata    = in_key;
        o_raddr    = r_pos;
        o_res      = '0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_out_free;
                if (i_in_valid && i_out_free) begin
                    if (i_in_item.action == ACT_PUSH) begin
                        o_we             = 1'b1;
                        n_ws             = (r_ws == LAST_SLOT) ? '0 : r_ws + AW'(1);
                        if (r_fill != LAST_SLOT) begin
                            n_fill = r_fill + AW'(1);
                        end
                        o_res.load       = 1'b1;
                        o_res.item.found = 1'b0;
                        o_res.item.slot  = SLOT_W'(r_ws);
                    end else begin
                        n_key  = in_key;
                        n_pos  = start_pos;
                        n_left = r_fill;
                        if (r_fill == '0) begin
                            // empty history is a miss right away
                            o_res.load = 1'b1;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (r_left != '0) begin
                    n_cmp_vld = 1'b1;
                    n_pos     = (r_pos == LAST_SLOT) ? '0 : r_pos + AW'(1);
                    n_left    = r_left - AW'(1);
                end
                // compare sees each entry in the cycle after its read address was presented
                if (hit) begin
                    n_res.found = 1'b1;
                    n_res.slot  = SLOT_W'(r_cmp_pos);
                    n_cmp_vld   = 1'b0;
                    n_state     = ST_DONE;
                end else if (r_cmp_vld && r_cmp_last) begin
                    n_res     = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    o_res.item = r_res;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_cmp_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |-> !r_cmp_vld)
        else $error("compare stage busy outside of a scan");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && r_state == ST_IDLE) |=> (r_fill != '0))
        else $error("fill count empty after a push");

    a_ws_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ws <= LAST_SLOT) && (r_fill <= LAST_SLOT))
        else $error("ring pointer out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.load |-> i_out_free)
        else $error("result loaded while output register busy");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == ST_IDLE && i_in_valid && !o_in_stall))
        else $error("ram write without an accepted push");

endmodule

// ===== hdl/history_ring_key_search.sv =====
// ----------------------------------------------------------------------------
// history_ring_key_search
// Ring of recent item keys with an oldest-first associative search.
// ----------------------------------------------------------------------------
// A push stores the three keys at the write slot and returns that slot in the
// next cycle. A search reads the key ram one entry per cycle over the
// searchable window (up to DEPTH-1 entries, oldest first) and compares each
// against the given keys in a single compare unit; it stops early on a hit,
// and its pace is bounded by the single ram read port. One item is in work at
// a time. A finished result waits in an output register, and the next item
// can be taken as that register drains.
// ----------------------------------------------------------------------------
module history_ring_key_search
    import hrks_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              out_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [REC_W-1:0]  ram_wdata;
    logic [REC_W-1:0]  ram_rdata;
    t_seq_res          seq_res;

    logic              r_out_valid;
    t_out_item         r_out_item;

    assign out_free = !r_out_valid || !i_out_stall;

    hrks_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hrks_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_out_free (out_free),
        .i_rd_data  (ram_rdata),
        .o_in_stall (o_in_stall),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_raddr    (ram_raddr),
        .o_res      (seq_res)
    );

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (seq_res.load) begin
            r_out_item <= seq_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
